// ===== rtl/core/rcc_pkg.sv =====
// Shared constants and types for the row/column transposition cipher.
// Holds register widths, reset values and configuration register indexes.
// No dependencies.
package rcc_pkg;

	localparam int BYTE_W      = 8;
	localparam int ROW_REG_W   = 6;
	localparam int COL_REG_W   = 21;
	localparam int CFG_DATA_W  = 21;
	localparam int ROW_ENTRY_W = 2;
	localparam int COL_ENTRY_W = 3;

	localparam int ROW_REG_ENTRIES = ROW_REG_W / ROW_ENTRY_W;
	localparam int COL_REG_ENTRIES = COL_REG_W / COL_ENTRY_W;

	localparam logic [ROW_REG_W-1:0] ROW_ORDER_RESET    = 6'd33;
	localparam logic [COL_REG_W-1:0] COLUMN_ORDER_RESET = 21'd1426817;

	typedef enum logic [0:0] {
		CFG_ROW_ORDER    = 1'b0,
		CFG_COLUMN_ORDER = 1'b1
	} cfg_index_t;

endpackage

// ===== rtl/core/rcc_tables.sv =====
// Configuration registers for the row and column order tables, decoded into
// clamped per-entry source indexes. Depends on rcc_pkg.
module rcc_tables #(
	parameter int ROWS    = 3,
	parameter int COLUMNS = 7,
	parameter int RW      = $clog2(ROWS),
	parameter int CW      = $clog2(COLUMNS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rcc_pkg::cfg_index_t           cfg_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [ROWS-1:0][RW-1:0]       row_tab,
	output logic [COLUMNS-1:0][CW-1:0]    col_tab
);
	import rcc_pkg::*;

	logic [ROW_REG_W-1:0] row_order_q;
	logic [COL_REG_W-1:0] column_order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_order_q    <= ROW_ORDER_RESET;
			column_order_q <= COLUMN_ORDER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_ORDER:    row_order_q    <= cfg_data[ROW_REG_W-1:0];
				CFG_COLUMN_ORDER: column_order_q <= cfg_data[COL_REG_W-1:0];
			endcase
		end
	end

	// Entries above the register width read as zero; out-of-range entries clamp
	// to the last row or column.
	for (genvar i = 0; i < ROWS; i++) begin : g_row
		logic [ROW_ENTRY_W-1:0] raw;
		if (i < ROW_REG_ENTRIES) begin : g_in
			assign raw = row_order_q[i*ROW_ENTRY_W +: ROW_ENTRY_W];
		end else begin : g_out
			assign raw = '0;
		end
		assign row_tab[i] = (int'(raw) >= ROWS) ? RW'(ROWS - 1) : RW'(raw);
	end

	for (genvar j = 0; j < COLUMNS; j++) begin : g_col
		logic [COL_ENTRY_W-1:0] raw;
		if (j < COL_REG_ENTRIES) begin : g_in
			assign raw = column_order_q[j*COL_ENTRY_W +: COL_ENTRY_W];
		end else begin : g_out
			assign raw = '0;
		end
		assign col_tab[j] = (int'(raw) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(raw);
	end

endmodule

// ===== rtl/core/rcc_store.sv =====
// Two-bank block buffer: one write port and one read port with a registered,
// enabled read data output. Depends on rcc_pkg.
module rcc_store #(
	parameter int DEPTH = 42,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rcc_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [rcc_pkg::BYTE_W-1:0] rdata
);
	import rcc_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/row_column_transposition_cipher_top.sv =====
// Top level of the row/column transposition cipher.
// Depends on rcc_pkg, rcc_tables and rcc_store.
//
// Plaintext bytes enter on the s_ channel, one per beat, filling a ROWS by
// COLUMNS block in row-major order. When the last byte of a block is taken,
// the block is emitted on the m_ channel permuted: output position (r,c)
// carries the stored byte at row row_order[r] and column column_order[c].
// m_tlast marks the final beat of each block.
// The buffer holds two banks, so one block fills while the previous one is
// read out. Within a block both channels move one beat per cycle while not
// stalled; once the last input beat of a block is taken the reader starts
// it, and its first output beat comes from the registered read port. The
// input stalls on the last byte of a block while the previous block is
// still being read out.
// When m_tready is low the output register holds its beat and the reader
// waits. Reset empties the open block and drops any pending output and
// loads the default tables {1,0,2} and {1,0,6,2,4,3,5}.
// Tables are read while a block is read out, so cfg_we writes go between blocks.
module row_column_transposition_cipher_top #(
	parameter int ROWS    = 3,
	parameter int COLUMNS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rcc_pkg::cfg_index_t           cfg_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rcc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] plain_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rcc_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] cipher_byte
	output logic                          m_tlast
);
	import rcc_pkg::*;

	localparam int BLOCK = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int FW    = $clog2(BLOCK);
	localparam int DEPTH = 2 * BLOCK;
	localparam int AW    = $clog2(DEPTH);

	logic [ROWS-1:0][RW-1:0]    row_tab;
	logic [COLUMNS-1:0][CW-1:0] col_tab;

	logic [FW-1:0] fill_q;
	logic          wr_bank_q;
	logic          rd_busy_q;
	logic          rd_bank_q;
	logic [RW-1:0] rd_row_q;
	logic [CW-1:0] rd_col_q;
	logic          m_tvalid_q;
	logic          m_tlast_q;

	logic          fill_last;
	logic          in_beat;
	logic          advance;
	logic          rd_en;
	logic          rd_last;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [RW-1:0] src_row;
	logic [CW-1:0] src_col;

	rcc_tables #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS),
		.RW      (RW),
		.CW      (CW)
	) u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_tab   (row_tab),
		.col_tab   (col_tab)
	);

	assign fill_last = (fill_q == FW'(BLOCK - 1));
	assign s_tready  = !(fill_last && rd_busy_q);
	assign in_beat   = s_tvalid && s_tready;
	assign wr_addr   = (wr_bank_q ? AW'(BLOCK) : AW'(0)) + AW'(fill_q);

	assign advance = !m_tvalid_q || m_tready;
	assign rd_en   = advance && rd_busy_q;
	assign rd_last = (rd_row_q == RW'(ROWS - 1)) && (rd_col_q == CW'(COLUMNS - 1));
	assign src_row = row_tab[rd_row_q];
	assign src_col = col_tab[rd_col_q];
	assign rd_addr = (rd_bank_q ? AW'(BLOCK) : AW'(0))
		+ AW'(src_row) * AW'(COLUMNS) + AW'(src_col);

	rcc_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (in_beat),
		.waddr (wr_addr),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (m_tdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			wr_bank_q  <= 1'b0;
			rd_busy_q  <= 1'b0;
			rd_bank_q  <= 1'b0;
			rd_row_q   <= '0;
			rd_col_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (in_beat) begin
				if (fill_last) begin
					fill_q    <= '0;
					wr_bank_q <= ~wr_bank_q;
				end else begin
					fill_q <= fill_q + FW'(1);
				end
			end

			if (in_beat && fill_last) begin
				rd_busy_q <= 1'b1;
				rd_bank_q <= wr_bank_q;
				rd_row_q  <= '0;
				rd_col_q  <= '0;
			end else if (rd_en) begin
				if (rd_last) begin
					rd_busy_q <= 1'b0;
				end else if (rd_col_q == CW'(COLUMNS - 1)) begin
					rd_col_q <= '0;
					rd_row_q <= rd_row_q + RW'(1);
				end else begin
					rd_col_q <= rd_col_q + CW'(1);
				end
			end

			if (advance) begin
				m_tvalid_q <= rd_busy_q;
				m_tlast_q  <= rd_busy_q && rd_last;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/core/rcc_checker.sv =====
// Port-level assertions for the transposition cipher top level, with the
// bind that attaches them. Depends on rcc_pkg and the top level.
module rcc_checker #(
	parameter int ROWS    = 3,
	parameter int COLUMNS = 7
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [rcc_pkg::BYTE_W-1:0] m_tdata,
	input logic                       m_tlast
);
	import rcc_pkg::*;

	localparam int BLOCK = ROWS * COLUMNS;
	localparam int FW    = $clog2(BLOCK);

	logic [FW-1:0] in_cnt_q;
	logic [FW-1:0] out_cnt_q;
	logic [1:0]    pend_q;
	logic          in_beat;
	logic          out_beat;
	logic          blk_in;
	logic          blk_out;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign blk_in   = in_beat && (in_cnt_q == FW'(BLOCK - 1));
	assign blk_out  = out_beat && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			pend_q    <= '0;
		end else begin
			if (in_beat) begin
				in_cnt_q <= blk_in ? '0 : in_cnt_q + FW'(1);
			end
			if (out_beat) begin
				out_cnt_q <= (out_cnt_q == FW'(BLOCK - 1)) ? '0 : out_cnt_q + FW'(1);
			end
			if (blk_in && !blk_out) begin
				pend_q <= pend_q + 2'd1;
			end else if (blk_out && !blk_in) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("Stalled output beat changed.");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_tlast |-> out_cnt_q == FW'(BLOCK - 1))
		else $error("Block end flagged early.");

	a_last_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_cnt_q == FW'(BLOCK - 1) |-> m_tlast)
		else $error("Block end missing on the final beat.");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("Output beat without a completed input block.");

endmodule

bind row_column_transposition_cipher_top rcc_checker #(
	.ROWS    (ROWS),
	.COLUMNS (COLUMNS)
) u_rcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
